### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with active-low reset disable.
`define SVIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("svic check failed");

// Implication form: antecedent holds, consequent follows in the same cycle.
`define SVIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `SVIC_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Implication form: consequent follows in the next cycle.
`define SVIC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  `SVIC_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

### hw/rtl/svic_pkg.sv
// ----------------------------------------------------------------------------
// svic_pkg
// Types, codes and constants of the sprite VM instruction core.
// ----------------------------------------------------------------------------
package svic_pkg;

  localparam int unsigned MemoryBytes  = 4096;
  localparam int unsigned MemAw        = 12;
  localparam int unsigned ScreenWidth  = 64;
  localparam int unsigned ScreenHeight = 32;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned FontBytes    = 80;
  localparam logic [11:0] FontBase     = 12'h050;
  localparam logic [11:0] PcStart      = 12'h200;

  // request commands
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_EXEC = 2'd1;
  localparam logic [1:0] CMD_SCRN = 2'd2;
  localparam logic [1:0] CMD_MRD  = 2'd3;

  // opcode groups (top nibble)
  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER  = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OPW_CLS = 16'h00E0;
  localparam logic [15:0] OPW_RET = 16'h00EE;

  // ALU sub codes
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  // key and misc sub codes
  localparam logic [7:0] KEY_SKP  = 8'h9E;
  localparam logic [7:0] KEY_SKNP = 8'hA1;
  localparam logic [7:0] F_GDLY   = 8'h07;
  localparam logic [7:0] F_WKEY   = 8'h0A;
  localparam logic [7:0] F_SDLY   = 8'h15;
  localparam logic [7:0] F_SSND   = 8'h18;
  localparam logic [7:0] F_ADDI   = 8'h1E;
  localparam logic [7:0] F_FONT   = 8'h29;
  localparam logic [7:0] F_BCD    = 8'h33;
  localparam logic [7:0] F_STR    = 8'h55;
  localparam logic [7:0] F_LDR    = 8'h65;

  localparam logic [7:0] FONT [FontBytes] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  load_byte;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;
  } req_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [63:0] read_value;
    logic        sound_on;
    logic        waiting_key;
    logic        screen_changed;
  } rsp_t;

  typedef enum logic [4:0] {
    UOP_NOP,
    UOP_INIT_WR,
    UOP_LOAD_WR,
    UOP_MEM_RD,
    UOP_MEM_CAP,
    UOP_RD_SCREEN,
    UOP_FETCH_HI,
    UOP_FETCH_LO,
    UOP_OP_CAP,
    UOP_RD_A,
    UOP_RD_B,
    UOP_EXEC,
    UOP_IDX_RD,
    UOP_DRAW_ROW,
    UOP_DRAW_END,
    UOP_BCD_WR,
    UOP_STORE_WR,
    UOP_LOAD_CAP,
    UOP_TICK
  } uop_e;

  typedef struct packed {
    uop_e        uop;
    logic [11:0] k;
    logic        latch;
    logic        out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0]  req_cmd;
    logic [15:0] op;
  } dp_status_t;

  function automatic logic [7:0] font_byte(input logic [11:0] a);
    logic [11:0] off;
    off = a - FontBase;
    if (a >= FontBase && off < 12'(FontBytes)) return FONT[off[6:0]];
    return 8'h00;
  endfunction

endpackage

### hw/rtl/svic_ram.sv
// ----------------------------------------------------------------------------
// svic_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module svic_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/svic_dp.sv
// ----------------------------------------------------------------------------
// svic_dp
// Datapath: machine state, program memory, screen and micro-op execution.
// ----------------------------------------------------------------------------
module svic_dp #(
  parameter int unsigned StackDepth = svic_pkg::StackDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  svic_pkg::req_t         in_i,
  input  svic_pkg::ctrl_cmd_t    cmd_i,
  output svic_pkg::dp_status_t   status_o,
  output svic_pkg::rsp_t         out_o
);
  import svic_pkg::*;

  localparam int unsigned SpW = $clog2(StackDepth);

  req_t        req_q;
  logic [15:0] op_q;
  logic [7:0]  a_q, b_q;
  logic [7:0]  v_q [16];
  logic [11:0] stack_q [StackDepth];
  logic [SpW-1:0] sp_q;
  logic [11:0] pc_q;
  logic [15:0] idx_q;
  logic [7:0]  dly_q, snd_q;
  logic [63:0] scr_q [ScreenHeight];
  logic        hit_q, wait_q, chg_q;
  logic [63:0] rv_q;
  rsp_t        out_q;

  logic [3:0]  x, y, n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign kk  = op_q[7:0];
  assign nnn = op_q[11:0];

  logic [MemAw-1:0] mem_addr;
  logic             mem_we;
  logic [7:0]       mem_wdata, mem_rdata;

  logic [11:0] idx_k;
  logic [3:0]  reg_ra;
  logic [7:0]  reg_rd;
  logic [4:0]  scr_ra;
  logic [63:0] scr_rd;
  logic [63:0] spr_w, spr_m;
  logic [127:0] spr_rot;
  logic [SpW-1:0] sp_inc, sp_dec;
  logic [1:0]  bcd_h;
  logic [6:0]  bcd_r;
  logic [14:0] bcd_p;
  logic [3:0]  bcd_t, bcd_o, bcd_d;
  logic [3:0]  key_num;
  logic        key_hit;
  logic [8:0]  sum9;

  assign idx_k = idx_q[11:0] + cmd_i.k;

  always_comb begin
    bcd_h = (a_q >= 8'd200) ? 2'd2 : ((a_q >= 8'd100) ? 2'd1 : 2'd0);
    bcd_r = 7'(a_q - 8'(bcd_h) * 8'd100);
    bcd_p = 15'(bcd_r) * 15'd205;
    bcd_t = bcd_p[14:11];
    bcd_o = 4'(bcd_r - 7'(bcd_t) * 7'd10);
    unique case (cmd_i.k[1:0])
      2'd0:    bcd_d = {2'b00, bcd_h};
      2'd1:    bcd_d = bcd_t;
      default: bcd_d = bcd_o;
    endcase
  end

  always_comb begin
    mem_addr  = pc_q;
    mem_we    = 1'b0;
    mem_wdata = 8'h00;
    reg_ra    = cmd_i.k[3:0];
    unique case (cmd_i.uop)
      UOP_INIT_WR: begin
        mem_addr  = cmd_i.k;
        mem_we    = 1'b1;
        mem_wdata = font_byte(cmd_i.k);
      end
      UOP_LOAD_WR: begin
        mem_addr  = req_q.address;
        mem_we    = 1'b1;
        mem_wdata = req_q.load_byte;
      end
      UOP_MEM_RD:   mem_addr = req_q.address;
      UOP_FETCH_LO: mem_addr = pc_q + 12'd1;
      UOP_IDX_RD:   mem_addr = idx_k;
      UOP_BCD_WR: begin
        mem_addr  = idx_k;
        mem_we    = 1'b1;
        mem_wdata = {4'h0, bcd_d};
      end
      UOP_STORE_WR: begin
        mem_addr  = idx_k;
        mem_we    = 1'b1;
        mem_wdata = reg_rd;
      end
      UOP_RD_A: reg_ra = x;
      UOP_RD_B: reg_ra = (op_q[15:12] == OP_JPV0) ? 4'h0 : y;
      default: ;
    endcase
  end

  assign reg_rd = v_q[reg_ra];

  svic_ram #(
    .Width (8),
    .Depth (MemoryBytes)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign scr_ra = (cmd_i.uop == UOP_RD_SCREEN) ? req_q.address[4:0]
                                               : b_q[4:0] + cmd_i.k[4:0];
  assign scr_rd = scr_q[scr_ra];

  always_comb begin
    spr_w = '0;
    for (int c = 0; c < 8; c++) begin
      spr_w[c] = mem_rdata[7-c];
    end
    spr_rot = {spr_w, spr_w} << a_q[5:0];
    spr_m   = spr_rot[127:64];
  end

  always_comb begin
    key_num = 4'h0;
    for (int i = 15; i >= 0; i--) begin
      if (req_q.keys_down[i]) key_num = 4'(i);
    end
    key_hit = |req_q.keys_down;
  end

  assign sp_inc = (sp_q == SpW'(StackDepth - 1)) ? '0 : sp_q + 1'b1;
  assign sp_dec = (sp_q == '0) ? SpW'(StackDepth - 1) : sp_q - 1'b1;
  assign sum9   = {1'b0, a_q} + {1'b0, b_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) req_q <= in_i;
    if (cmd_i.uop == UOP_FETCH_LO) op_q[15:8] <= mem_rdata;
    if (cmd_i.uop == UOP_OP_CAP) op_q[7:0] <= mem_rdata;
    if (cmd_i.uop == UOP_RD_A) a_q <= reg_rd;
    if (cmd_i.uop == UOP_RD_B) b_q <= reg_rd;
    if (cmd_i.uop == UOP_EXEC && op_q[15:12] == OP_CALL) stack_q[sp_q] <= pc_q;
    if (cmd_i.out_load) begin
      out_q.program_counter <= pc_q;
      out_q.read_value      <= rv_q;
      out_q.sound_on        <= (snd_q != 8'h00);
      out_q.waiting_key     <= wait_q;
      out_q.screen_changed  <= chg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) v_q[i] <= 8'h00;
      for (int r = 0; r < ScreenHeight; r++) scr_q[r] <= '0;
      sp_q   <= '0;
      pc_q   <= PcStart;
      idx_q  <= 16'h0000;
      dly_q  <= 8'h00;
      snd_q  <= 8'h00;
      hit_q  <= 1'b0;
      wait_q <= 1'b0;
      chg_q  <= 1'b0;
      rv_q   <= '0;
    end else begin
      if (cmd_i.latch) begin
        wait_q <= 1'b0;
        chg_q  <= 1'b0;
        rv_q   <= '0;
      end
      unique case (cmd_i.uop)
        UOP_MEM_CAP:   rv_q <= {56'h0, mem_rdata};
        UOP_RD_SCREEN: rv_q <= scr_rd;
        UOP_OP_CAP:    pc_q <= pc_q + 12'd2;
        UOP_DRAW_ROW: begin
          scr_q[scr_ra] <= scr_rd ^ spr_m;
          if (|(scr_rd & spr_m)) hit_q <= 1'b1;
        end
        UOP_DRAW_END:  v_q[15] <= {7'h00, hit_q};
        UOP_LOAD_CAP:  v_q[cmd_i.k[3:0]] <= mem_rdata;
        UOP_TICK: begin
          if (dly_q != 8'h00) dly_q <= dly_q - 8'd1;
          if (snd_q != 8'h00) snd_q <= snd_q - 8'd1;
        end
        UOP_EXEC: begin
          case (op_q[15:12])
            OP_SYS: begin
              if (op_q == OPW_CLS) begin
                for (int r = 0; r < ScreenHeight; r++) scr_q[r] <= '0;
                chg_q <= 1'b1;
              end else if (op_q == OPW_RET) begin
                sp_q <= sp_dec;
                pc_q <= stack_q[sp_dec];
              end
            end
            OP_JP: pc_q <= nnn;
            OP_CALL: begin
              sp_q <= sp_inc;
              pc_q <= nnn;
            end
            OP_SEI:  if (a_q == kk) pc_q <= pc_q + 12'd2;
            OP_SNEI: if (a_q != kk) pc_q <= pc_q + 12'd2;
            OP_SER:  if (a_q == b_q) pc_q <= pc_q + 12'd2;
            OP_SNER: if (a_q != b_q) pc_q <= pc_q + 12'd2;
            OP_LDI:  v_q[x] <= kk;
            OP_ADDI: v_q[x] <= a_q + kk;
            OP_ALU: begin
              case (n)
                ALU_MOV: v_q[x] <= b_q;
                ALU_OR:  v_q[x] <= a_q | b_q;
                ALU_AND: v_q[x] <= a_q & b_q;
                ALU_XOR: v_q[x] <= a_q ^ b_q;
                ALU_ADD: begin
                  v_q[15] <= {7'h00, sum9[8]};
                  v_q[x]  <= sum9[7:0];
                end
                ALU_SUB: begin
                  v_q[15] <= {7'h00, (a_q > b_q)};
                  v_q[x]  <= a_q - b_q;
                end
                ALU_SHR: begin
                  v_q[15] <= {7'h00, a_q[0]};
                  v_q[x]  <= {1'b0, a_q[7:1]};
                end
                ALU_SBN: begin
                  v_q[15] <= {7'h00, (b_q > a_q)};
                  v_q[x]  <= b_q - a_q;
                end
                ALU_SHL: begin
                  v_q[15] <= {7'h00, a_q[7]};
                  v_q[x]  <= {a_q[6:0], 1'b0};
                end
                default: ;
              endcase
            end
            OP_LDIX: idx_q <= {4'h0, nnn};
            OP_JPV0: pc_q <= nnn + {4'h0, b_q};
            OP_RND:  v_q[x] <= req_q.random_byte & kk;
            OP_DRW: begin
              hit_q <= 1'b0;
              chg_q <= 1'b1;
            end
            OP_KEY: begin
              if (kk == KEY_SKP && req_q.keys_down[a_q[3:0]]) pc_q <= pc_q + 12'd2;
              if (kk == KEY_SKNP && !req_q.keys_down[a_q[3:0]]) pc_q <= pc_q + 12'd2;
            end
            default: begin
              case (kk)
                F_GDLY: v_q[x] <= dly_q;
                F_WKEY: begin
                  if (key_hit) begin
                    v_q[x] <= {4'h0, key_num};
                  end else begin
                    pc_q   <= pc_q - 12'd2;
                    wait_q <= 1'b1;
                  end
                end
                F_SDLY: dly_q <= a_q;
                F_SSND: snd_q <= a_q;
                F_ADDI: idx_q <= idx_q + {8'h00, a_q};
                F_FONT: idx_q <= {4'h0, FontBase} + {6'h00, a_q, 2'b00} + {8'h00, a_q};
                default: ;
              endcase
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign status_o.req_cmd = req_q.command;
  assign status_o.op      = op_q;
  assign out_o            = out_q;

endmodule

### hw/rtl/svic_ctrl.sv
// ----------------------------------------------------------------------------
// svic_ctrl
// Sequencer: memory init, request dispatch and per-opcode micro-op stepping.
// ----------------------------------------------------------------------------
module svic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  svic_pkg::dp_status_t status_i,
  output svic_pkg::ctrl_cmd_t  cmd_o
);
  import svic_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LOADW, S_MRD, S_MCAP, S_SRD, S_F0, S_F1, S_F2,
    S_RA, S_RB, S_EX, S_DRD, S_DWR, S_DEND, S_BCD, S_STW, S_LRD, S_LCAP,
    S_TICK, S_FIN
  } state_e;

  state_e      state_q;
  logic [11:0] k_q;
  logic        out_valid_q;
  logic        accept, load_out;
  logic [3:0]  x, n;
  logic [7:0]  kk;

  assign x  = status_i.op[11:8];
  assign n  = status_i.op[3:0];
  assign kk = status_i.op[7:0];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o.k        = k_q;
    cmd_o.latch    = accept;
    cmd_o.out_load = load_out;
    unique case (state_q)
      S_INIT:  cmd_o.uop = UOP_INIT_WR;
      S_LOADW: cmd_o.uop = UOP_LOAD_WR;
      S_MRD:   cmd_o.uop = UOP_MEM_RD;
      S_MCAP:  cmd_o.uop = UOP_MEM_CAP;
      S_SRD:   cmd_o.uop = UOP_RD_SCREEN;
      S_F0:    cmd_o.uop = UOP_FETCH_HI;
      S_F1:    cmd_o.uop = UOP_FETCH_LO;
      S_F2:    cmd_o.uop = UOP_OP_CAP;
      S_RA:    cmd_o.uop = UOP_RD_A;
      S_RB:    cmd_o.uop = UOP_RD_B;
      S_EX:    cmd_o.uop = UOP_EXEC;
      S_DRD:   cmd_o.uop = UOP_IDX_RD;
      S_DWR:   cmd_o.uop = UOP_DRAW_ROW;
      S_DEND:  cmd_o.uop = UOP_DRAW_END;
      S_BCD:   cmd_o.uop = UOP_BCD_WR;
      S_STW:   cmd_o.uop = UOP_STORE_WR;
      S_LRD:   cmd_o.uop = UOP_IDX_RD;
      S_LCAP:  cmd_o.uop = UOP_LOAD_CAP;
      S_TICK:  cmd_o.uop = UOP_TICK;
      default: cmd_o.uop = UOP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      unique case (state_q)
        S_INIT: begin
          k_q <= k_q + 12'd1;
          if (k_q == 12'(MemoryBytes - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          k_q <= '0;
          if (accept) state_q <= S_F0;
          if (accept) begin
            unique case (1'b1)
              default: ;
            endcase
          end
        end
        S_LOADW: state_q <= S_FIN;
        S_MRD:   state_q <= S_MCAP;
        S_MCAP:  state_q <= S_FIN;
        S_SRD:   state_q <= S_FIN;
        S_F0:    state_q <= S_F1;
        S_F1:    state_q <= S_F2;
        S_F2:    state_q <= S_RA;
        S_RA:    state_q <= S_RB;
        S_RB:    state_q <= S_EX;
        S_EX: begin
          k_q <= '0;
          if (status_i.op[15:12] == OP_DRW) begin
            state_q <= (n == 4'h0) ? S_DEND : S_DRD;
          end else if (status_i.op[15:12] == OP_MISC && kk == F_BCD) begin
            state_q <= S_BCD;
          end else if (status_i.op[15:12] == OP_MISC && kk == F_STR) begin
            state_q <= S_STW;
          end else if (status_i.op[15:12] == OP_MISC && kk == F_LDR) begin
            state_q <= S_LRD;
          end else begin
            state_q <= S_TICK;
          end
        end
        S_DRD: state_q <= S_DWR;
        S_DWR: begin
          k_q <= k_q + 12'd1;
          state_q <= (k_q[3:0] == n - 4'd1) ? S_DEND : S_DRD;
        end
        S_DEND: state_q <= S_TICK;
        S_BCD: begin
          k_q <= k_q + 12'd1;
          if (k_q[1:0] == 2'd2) state_q <= S_TICK;
        end
        S_STW: begin
          k_q <= k_q + 12'd1;
          if (k_q[3:0] == x) state_q <= S_TICK;
        end
        S_LRD: state_q <= S_LCAP;
        S_LCAP: begin
          k_q <= k_q + 12'd1;
          state_q <= (k_q[3:0] == x) ? S_TICK : S_LRD;
        end
        S_TICK: state_q <= S_FIN;
        S_FIN: if (load_out) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
      if (state_q == S_IDLE && accept) begin
        unique case (status_i.req_cmd)
          default: ;
        endcase
      end
      if (state_q == S_IDLE && accept) begin
        state_q <= S_F0;
      end
      if (state_q == S_LOADW || state_q == S_SRD || state_q == S_MCAP) begin
        state_q <= S_FIN;
      end
      if (state_q == S_F0 && status_i.req_cmd == CMD_LOAD) state_q <= S_LOADW;
      if (state_q == S_F0 && status_i.req_cmd == CMD_SCRN) state_q <= S_SRD;
      if (state_q == S_F0 && status_i.req_cmd == CMD_MRD) state_q <= S_MRD;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/sprite_vm_instruction_core.sv
// ----------------------------------------------------------------------------
// sprite_vm_instruction_core
// Sixteen-bit sprite VM interpreter: load, execute, screen and memory readback.
// ----------------------------------------------------------------------------
// Sequencing: every request ends in S_FIN; a sprite draw reads and writes each
//   row in turn through the single program RAM port.
// Throughput: one request at a time; the next is taken once the result is
//   parked in the output register.
// Reset: state clears at once, then a pass over all program memory writes the
//   font and zeros; in_ready_o stays low until it finishes.
module sprite_vm_instruction_core #(
  parameter int unsigned StackDepth = svic_pkg::StackDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  svic_pkg::req_t  in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output svic_pkg::rsp_t  out_o
);
  import svic_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  svic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  svic_dp #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cmd_i    (cmd),
    .status_o (status),
    .out_o    (out_o)
  );

endmodule

### hw/rtl/svic_checker.sv
// ----------------------------------------------------------------------------
// svic_checker
// Port-level checks of the instruction core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svic_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input svic_pkg::req_t in_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input svic_pkg::rsp_t out_o
);

  logic unused_in;
  assign unused_in = ^in_i;

  // one request in flight: no back-to-back acceptance
  `SVIC_ASSERT_NXT(a_one_inflight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a parked result holds until taken
  `SVIC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_o))
  // a stalled key wait is an execute: no readback, no screen change
  `SVIC_ASSERT_IMP(a_wait_excl, clk_i, rst_ni, out_valid_o && out_o.waiting_key, !out_o.screen_changed && out_o.read_value == 64'h0)
  // a screen change only comes from an execute
  `SVIC_ASSERT_IMP(a_chg_norv, clk_i, rst_ni, out_valid_o && out_o.screen_changed, out_o.read_value == 64'h0)

endmodule

bind sprite_vm_instruction_core svic_checker u_svic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

### dv/svic_machine_checker.sv
// ----------------------------------------------------------------------------
// svic_machine_checker
// Watches the request and result channels of the sprite VM core, tracks the
// machine state (registers, memory, stack, timers, screen), predicts every
// result and compares it field by field against the DUT output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svic_machine_checker
  import svic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  req_t        in_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  rsp_t        out_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output logic [11:0] pc_o
);

  logic [7:0]  vreg   [16];
  logic [7:0]  mem    [MemoryBytes];
  logic [11:0] stk    [16];
  logic [3:0]  sp;
  logic [11:0] pc;
  logic [15:0] idx;
  logic [7:0]  dly;
  logic [7:0]  snd;
  logic [63:0] scr    [ScreenHeight];

  rsp_t predicted_rsp_q[$];

  assign pending_o = predicted_rsp_q.size();
  assign pc_o      = pc;

  function automatic void clear_machine();
    foreach (vreg[i]) vreg[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    for (int i = 0; i < FontBytes; i++) mem[FontBase + i] = FONT[i];
    foreach (stk[i]) stk[i] = '0;
    foreach (scr[i]) scr[i] = '0;
    sp  = '0;
    pc  = PcStart;
    idx = '0;
    dly = '0;
    snd = '0;
  endfunction

  function automatic logic draw_sprite(logic [3:0] x, logic [3:0] y, logic [3:0] n);
    logic [5:0] ox;
    logic [4:0] oy;
    logic [7:0] bits;
    logic [4:0] row;
    logic [5:0] col;
    logic       hit;
    ox  = vreg[x][5:0];
    oy  = vreg[y][4:0];
    hit = 1'b0;
    for (int r = 0; r < n; r++) begin
      bits = mem[12'(idx + r)];
      row  = 5'(oy + r);
      for (int c = 0; c < 8; c++) begin
        if (bits[7-c]) begin
          col = 6'(ox + c);
          if (scr[row][col]) hit = 1'b1;
          scr[row][col] = ~scr[row][col];
        end
      end
    end
    return hit;
  endfunction

  function automatic void run_insn(logic [15:0] keys, logic [7:0] rnd,
                                   output logic waiting, output logic changed);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, a, b;
    logic [11:0] nnn;
    logic [8:0]  sum;
    int          k;
    op  = {mem[pc], mem[12'(pc + 1)]};
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    kk  = op[7:0];
    nnn = op[11:0];
    waiting = 1'b0;
    changed = 1'b0;
    pc = pc + 12'd2;
    case (op[15:12])
      OP_SYS: begin
        if (op == OPW_CLS) begin
          foreach (scr[i]) scr[i] = '0;
          changed = 1'b1;
        end else if (op == OPW_RET) begin
          sp = sp - 4'd1;
          pc = stk[sp];
        end
      end
      OP_JP: pc = nnn;
      OP_CALL: begin
        stk[sp] = pc;
        sp = sp + 4'd1;
        pc = nnn;
      end
      OP_SEI:  if (vreg[x] == kk) pc = pc + 12'd2;
      OP_SNEI: if (vreg[x] != kk) pc = pc + 12'd2;
      OP_SER:  if (vreg[x] == vreg[y]) pc = pc + 12'd2;
      OP_LDI:  vreg[x] = kk;
      OP_ADDI: vreg[x] = vreg[x] + kk;
      OP_ALU: begin
        a = vreg[x];
        b = vreg[y];
        case (n)
          ALU_MOV: vreg[x] = b;
          ALU_OR:  vreg[x] = a | b;
          ALU_AND: vreg[x] = a & b;
          ALU_XOR: vreg[x] = a ^ b;
          ALU_ADD: begin
            sum = a + b;
            vreg[15] = {7'd0, sum[8]};
            vreg[x] = sum[7:0];
          end
          ALU_SUB: begin
            vreg[15] = {7'd0, a > b};
            vreg[x] = a - b;
          end
          ALU_SHR: begin
            vreg[15] = {7'd0, a[0]};
            vreg[x] = a >> 1;
          end
          ALU_SBN: begin
            vreg[15] = {7'd0, b > a};
            vreg[x] = b - a;
          end
          ALU_SHL: begin
            vreg[15] = {7'd0, a[7]};
            vreg[x] = a << 1;
          end
          default: ;
        endcase
      end
      OP_SNER: if (vreg[x] != vreg[y]) pc = pc + 12'd2;
      OP_LDIX: idx = {4'd0, nnn};
      OP_JPV0: pc = nnn + {4'd0, vreg[0]};
      OP_RND:  vreg[x] = rnd & kk;
      OP_DRW: begin
        vreg[15] = '0;
        vreg[15] = {7'd0, draw_sprite(x, y, n)};
        changed = 1'b1;
      end
      OP_KEY: begin
        if (kk == KEY_SKP && keys[vreg[x][3:0]]) pc = pc + 12'd2;
        else if (kk == KEY_SKNP && !keys[vreg[x][3:0]]) pc = pc + 12'd2;
      end
      default: begin
        case (kk)
          F_GDLY: vreg[x] = dly;
          F_WKEY: begin
            k = -1;
            for (int i = 15; i >= 0; i--) if (keys[i]) k = i;
            if (k >= 0) vreg[x] = 8'(k);
            else begin
              pc = pc - 12'd2;
              waiting = 1'b1;
            end
          end
          F_SDLY: dly = vreg[x];
          F_SSND: snd = vreg[x];
          F_ADDI: idx = idx + {8'd0, vreg[x]};
          F_FONT: idx = 16'(FontBase) + 16'(5 * vreg[x]);
          F_BCD: begin
            mem[idx[11:0]]     = vreg[x] / 100;
            mem[12'(idx + 1)]  = (vreg[x] / 10) % 10;
            mem[12'(idx + 2)]  = vreg[x] % 10;
          end
          F_STR: for (int i = 0; i <= x; i++) mem[12'(idx + i)] = vreg[i];
          F_LDR: for (int i = 0; i <= x; i++) vreg[i] = mem[12'(idx + i)];
          default: ;
        endcase
      end
    endcase
    if (dly != 0) dly = dly - 8'd1;
    if (snd != 0) snd = snd - 8'd1;
  endfunction

  function automatic rsp_t interp_step(req_t r);
    rsp_t rsp;
    logic w, c;
    rsp = '0;
    w = 1'b0;
    c = 1'b0;
    case (r.command)
      CMD_LOAD: mem[r.address] = r.load_byte;
      CMD_EXEC: run_insn(r.keys_down, r.random_byte, w, c);
      CMD_SCRN: rsp.read_value = scr[r.address[4:0]];
      default:  rsp.read_value = {56'd0, mem[r.address]};
    endcase
    rsp.program_counter = pc;
    rsp.sound_on        = (snd != 0);
    rsp.waiting_key     = w;
    rsp.screen_changed  = c;
    return rsp;
  endfunction

  function automatic void flag_mismatch(rsp_t exp_r, rsp_t got);
    fail_cnt_o++;
    if (fail_cnt_o <= 10)
      $display("mismatch: expected pc=%h rv=%h snd=%b wait=%b chg=%b, got pc=%h rv=%h snd=%b wait=%b chg=%b",
               exp_r.program_counter, exp_r.read_value, exp_r.sound_on, exp_r.waiting_key,
               exp_r.screen_changed, got.program_counter, got.read_value, got.sound_on,
               got.waiting_key, got.screen_changed);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_r;
    if (!rst_ni) begin
      clear_machine();
      predicted_rsp_q.delete();
      fail_cnt_o = 0;
      checked_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (predicted_rsp_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10) $display("unexpected result: pc=%h", out_i.program_counter);
        end else begin
          exp_r = predicted_rsp_q.pop_front();
          if (out_i.program_counter !== exp_r.program_counter ||
              out_i.read_value !== exp_r.read_value ||
              out_i.sound_on !== exp_r.sound_on ||
              out_i.waiting_key !== exp_r.waiting_key ||
              out_i.screen_changed !== exp_r.screen_changed)
            flag_mismatch(exp_r, out_i);
        end
      end
      if (in_valid_i && in_ready_i) predicted_rsp_q.push_back(interp_step(in_i));
    end
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sprite VM core: primes the return stack, runs directed
// opcode corner cases, then loads random programs at the current pc and runs
// them with random keys, readbacks and handshake gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import svic_pkg::*;

  localparam int unsigned ItemTarget = 1050;
  localparam int unsigned IdleLimit  = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  req_t        in_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rsp_t        out_o;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;
  logic [11:0] model_pc;

  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          hold_rx;
  bit          burst;

  sprite_vm_instruction_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o
  );

  svic_machine_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_i(out_o),
    .fail_cnt_o(fail_cnt), .pending_o(pending), .checked_o(checked), .pc_o(model_pc)
  );

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_i        = '0;
    out_ready_i = 1'b0;
  end

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(6, 1)) @(posedge clk_i);
        if (pick_gap() != 0) begin
          out_ready_i <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send(req_t r);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic req_t mk_req(logic [1:0] cmd, logic [11:0] addr, logic [7:0] data,
                                  logic [15:0] keys);
    req_t r;
    r.command     = cmd;
    r.address     = addr;
    r.load_byte   = data;
    r.keys_down   = keys;
    r.random_byte = 8'($urandom);
    return r;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_keys();
    if ($urandom_range(2) == 0) return '0;
    if ($urandom_range(1) == 0) return 16'(1) << $urandom_range(15);
    return 16'($urandom);
  endfunction

  // loads the words at the current pc, then executes them plus a few extras
  task automatic run_words(logic [15:0] words[$], int unsigned extra, bit noisy);
    logic [11:0] base;
    wait_drained();
    base = model_pc;
    foreach (words[i]) begin
      send(mk_req(CMD_LOAD, 12'(base + 2 * i), words[i][15:8], 16'($urandom)));
      send(mk_req(CMD_LOAD, 12'(base + 2 * i + 1), words[i][7:0], 16'($urandom)));
    end
    for (int i = 0; i < words.size() + extra; i++) begin
      if (noisy && $urandom_range(7) == 0)
        send(mk_req($urandom_range(1) ? CMD_SCRN : CMD_MRD, 12'($urandom), 8'($urandom),
                    16'($urandom)));
      send(mk_req(CMD_EXEC, 12'($urandom), 8'($urandom), rand_keys()));
    end
  endtask

  function automatic logic [15:0] rand_insn();
    logic [3:0]  g;
    logic [11:0] nnn;
    logic [7:0]  subs[11];
    logic [3:0]  alus[9];
    subs = '{F_GDLY, F_WKEY, F_SDLY, F_SSND, F_ADDI, F_FONT, F_BCD, F_STR, F_LDR,
             8'h00, 8'hFF};
    alus = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SBN, ALU_SHL};
    g   = 4'($urandom);
    nnn = ($urandom_range(3) == 0) ? 12'($urandom) : 12'h200 + 12'($urandom_range(255));
    case (g)
      OP_SYS: begin
        case ($urandom_range(3))
          0: return OPW_CLS;
          1: return OPW_RET;
          default: return {OP_SYS, 12'($urandom)};
        endcase
      end
      OP_JP, OP_CALL, OP_LDIX, OP_JPV0: return {g, nnn};
      OP_ALU: return {OP_ALU, 8'($urandom),
                      ($urandom_range(9) == 0) ? 4'($urandom) : alus[$urandom_range(8)]};
      OP_KEY: begin
        case ($urandom_range(2))
          0: return {OP_KEY, 4'($urandom), KEY_SKP};
          1: return {OP_KEY, 4'($urandom), KEY_SKNP};
          default: return {OP_KEY, 12'($urandom)};
        endcase
      end
      OP_MISC: return {OP_MISC, 4'($urandom), subs[$urandom_range(10)]};
      OP_DRW: return {OP_DRW, 8'($urandom),
                      ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(5))};
      default: return 16'($urandom) & 16'h0FFF | {g, 12'd0};
    endcase
  endfunction

  initial begin
    logic [15:0] words[$];
    int unsigned phase;
    items_sent = 0;
    phase      = 0;
    hold_rx    = 1'b0;
    burst      = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // call to itself sixteen times so every stack entry holds a return address
    words = '{{OP_CALL, PcStart}};
    run_words(words, 15, 1'b0);

    // directed corners
    send(mk_req(CMD_LOAD, 12'hFFF, 8'hFF, 16'hFFFF));
    send(mk_req(CMD_MRD, 12'hFFF, 8'h00, 16'h0000));
    send(mk_req(CMD_MRD, FontBase, 8'h00, 16'h0000));
    words = '{16'h60FF, 16'h6101, 16'h8014, 16'h8F16, 16'h8F0E, 16'h8009, 16'h5011,
              16'h603F, 16'h611F, 16'hA050, 16'hD01F, 16'hD015, 16'hD010, 16'hF00A,
              16'h00E0, 16'hE09E, 16'hE0A1, 16'h00EE};
    run_words(words, 0, 1'b0);
    send(mk_req(CMD_SCRN, 12'hFFF, 8'h00, 16'h0000));

    while (items_sent < ItemTarget) begin
      phase++;
      burst = ($urandom_range(4) == 0);
      words.delete();
      repeat ($urandom_range(16, 4)) words.push_back(rand_insn());
      if (phase == 3) begin
        wait_drained();
        hold_rx = 1'b1;
      end
      run_words(words, $urandom_range(12), 1'b1);
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests over %0d random program phases, %0d results checked",
             items_sent, phase, checked);
    if (fail_cnt == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sprite_vm_instruction_core.f
+incdir+hw/rtl
hw/rtl/svic_pkg.sv
hw/rtl/svic_ram.sv
hw/rtl/svic_dp.sv
hw/rtl/svic_ctrl.sv
hw/rtl/sprite_vm_instruction_core.sv
hw/rtl/svic_checker.sv
dv/svic_machine_checker.sv
dv/tb.sv
